/* rtl/escape_time_cubic_fractal_pixel_top_macros.svh */
// Assertion helpers; expect clk and rst_n in scope.
`ifndef ESCAPE_TIME_CUBIC_FRACTAL_PIXEL_TOP_MACROS_SVH
`define ESCAPE_TIME_CUBIC_FRACTAL_PIXEL_TOP_MACROS_SVH

`define ETCF_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define ETCF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/etcf_pkg.sv */
`default_nettype none
package etcf_pkg;

    localparam int FRAC_BITS = 26;
    localparam int DIM_WIDTH = 12;
    localparam int CFG_W     = 32;
    localparam int IDX_W     = 3;
    localparam int EDGE_W    = 32;
    localparam int CNT_W     = DIM_WIDTH + 1;
    localparam int ITER_W    = 16;
    localparam int QUO_W     = 32;
    localparam int PT_W      = 48;
    localparam int VAL_W     = 32;
    localparam int COLOR_W   = 8;

    localparam logic [IDX_W-1:0] REG_LEFT   = 3'd0;
    localparam logic [IDX_W-1:0] REG_RIGHT  = 3'd1;
    localparam logic [IDX_W-1:0] REG_BOTTOM = 3'd2;
    localparam logic [IDX_W-1:0] REG_TOP    = 3'd3;
    localparam logic [IDX_W-1:0] REG_WIDTH  = 3'd4;
    localparam logic [IDX_W-1:0] REG_HEIGHT = 3'd5;
    localparam logic [IDX_W-1:0] REG_LIMIT  = 3'd6;

    localparam logic [PT_W-1:0]  ESC_TWO  = PT_W'(2) << FRAC_BITS;
    localparam logic [VAL_W-1:0] ESC_FOUR = VAL_W'(4) << FRAC_BITS;
    localparam logic [COLOR_W-1:0] COLOR_ON  = 8'd255;
    localparam logic [COLOR_W-1:0] COLOR_OFF = 8'd0;

    typedef struct packed {
        logic signed [EDGE_W-1:0] left_edge;
        logic signed [EDGE_W-1:0] right_edge;
        logic signed [EDGE_W-1:0] bottom_edge;
        logic signed [EDGE_W-1:0] top_edge;
        logic [CNT_W-1:0]         image_width;
        logic [CNT_W-1:0]         image_height;
        logic [ITER_W-1:0]        iteration_limit;
    } cfg_t;

    typedef struct packed {
        logic signed [PT_W-1:0] x;
        logic signed [PT_W-1:0] y;
    } point_t;

    // product shifted down by FRAC_BITS, magnitude truncated toward zero
    function automatic logic signed [VAL_W-1:0] fx_mul(input logic signed [VAL_W-1:0] a,
                                                      input logic signed [VAL_W-1:0] b);
        logic [VAL_W-1:0]   ma;
        logic [VAL_W-1:0]   mb;
        logic [2*VAL_W-1:0] p;
        logic [VAL_W-1:0]   r;
        ma = a[VAL_W-1] ? VAL_W'(-a) : VAL_W'(a);
        mb = b[VAL_W-1] ? VAL_W'(-b) : VAL_W'(b);
        p  = (2*VAL_W)'(ma) * (2*VAL_W)'(mb);
        r  = p[FRAC_BITS +: VAL_W];
        return (a[VAL_W-1] ^ b[VAL_W-1]) ? -$signed(r) : $signed(r);
    endfunction

endpackage
`default_nettype wire

/* rtl/etcf_ifs.sv */
`default_nettype none
interface etcf_pix_if;
    logic                           valid;
    logic                           ready;
    logic [etcf_pkg::DIM_WIDTH-1:0] column;
    logic [etcf_pkg::DIM_WIDTH-1:0] row;
    modport source (output valid, output column, output row, input ready);
    modport sink (input valid, input column, input row, output ready);
endinterface

interface etcf_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       escaped;
    modport source (output valid, output red, output green, output blue, output alpha,
                    output escaped, input ready);
    modport sink (input valid, input red, input green, input blue, input alpha,
                  input escaped, output ready);
endinterface
`default_nettype wire

/* rtl/etcf_front.sv */
`default_nettype none
module etcf_front (
    input  wire logic           clk,
    input  wire logic           rst_n,
    etcf_pix_if.sink            pix,
    input  wire etcf_pkg::cfg_t cfg,
    input  wire logic           full,
    output logic                push,
    output etcf_pkg::point_t    push_data
);
    import etcf_pkg::*;

    localparam logic [2:0] F_IDLE = 3'd0;
    localparam logic [2:0] F_DIV  = 3'd1;
    localparam logic [2:0] F_MUL  = 3'd2;
    localparam logic [2:0] F_ADD  = 3'd3;
    localparam logic [2:0] F_PUSH = 3'd4;
    localparam int DCNT_W = $clog2(QUO_W);

    logic [2:0]              state_reg, state_next;
    logic [DCNT_W-1:0]       cnt_reg;
    logic [DIM_WIDTH-1:0]    col_reg, row_reg;
    logic [QUO_W-1:0]        qx_reg, qy_reg;
    logic [CNT_W-1:0]        rx_reg, ry_reg;
    logic [CNT_W-1:0]        dx_div_reg, dy_div_reg;
    logic                    negx_reg, negy_reg;
    logic signed [PT_W-1:0]  px_reg, py_reg;
    point_t                  pt_reg;

    logic signed [EDGE_W:0]  diff_x, diff_y;
    logic [CNT_W:0]          shx, shy;
    logic                    bx, by;
    logic [PT_W-1:0]         mx, my;
    logic                    accept;

    assign accept = pix.valid && pix.ready;
    assign pix.ready = (state_reg == F_IDLE);
    assign push = (state_reg == F_PUSH) && !full;
    assign push_data = pt_reg;

    assign diff_x = (EDGE_W+1)'(cfg.right_edge) - (EDGE_W+1)'(cfg.left_edge);
    assign diff_y = (EDGE_W+1)'(cfg.top_edge) - (EDGE_W+1)'(cfg.bottom_edge);

    assign shx = {rx_reg, qx_reg[QUO_W-1]};
    assign shy = {ry_reg, qy_reg[QUO_W-1]};
    assign bx  = shx >= {1'b0, dx_div_reg};
    assign by  = shy >= {1'b0, dy_div_reg};

    assign mx = PT_W'(col_reg) * PT_W'(qx_reg);
    assign my = PT_W'(row_reg) * PT_W'(qy_reg);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE: if (accept) state_next = F_DIV;
            F_DIV:  if (cnt_reg == DCNT_W'(QUO_W - 1)) state_next = F_MUL;
            F_MUL:  state_next = F_ADD;
            F_ADD:  state_next = F_PUSH;
            F_PUSH: if (!full) state_next = F_IDLE;
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            col_reg    <= pix.column;
            row_reg    <= pix.row;
            negx_reg   <= diff_x[EDGE_W];
            negy_reg   <= diff_y[EDGE_W];
            qx_reg     <= QUO_W'(diff_x[EDGE_W] ? -diff_x : diff_x);
            qy_reg     <= QUO_W'(diff_y[EDGE_W] ? -diff_y : diff_y);
            rx_reg     <= '0;
            ry_reg     <= '0;
            dx_div_reg <= (cfg.image_width == '0) ? CNT_W'(1) : cfg.image_width;
            dy_div_reg <= (cfg.image_height == '0) ? CNT_W'(1) : cfg.image_height;
            cnt_reg    <= '0;
        end
        else if (state_reg == F_DIV)
        begin
            rx_reg  <= bx ? CNT_W'(shx - {1'b0, dx_div_reg}) : CNT_W'(shx);
            ry_reg  <= by ? CNT_W'(shy - {1'b0, dy_div_reg}) : CNT_W'(shy);
            qx_reg  <= {qx_reg[QUO_W-2:0], bx};
            qy_reg  <= {qy_reg[QUO_W-2:0], by};
            cnt_reg <= cnt_reg + DCNT_W'(1);
        end
        if (state_reg == F_MUL)
        begin
            px_reg <= negx_reg ? -$signed(mx) : $signed(mx);
            py_reg <= negy_reg ? -$signed(my) : $signed(my);
        end
        if (state_reg == F_ADD)
        begin
            pt_reg.x <= PT_W'(cfg.left_edge) + px_reg;
            pt_reg.y <= PT_W'(cfg.top_edge) - py_reg;
        end
    end
endmodule
`default_nettype wire

/* rtl/etcf_queue.sv */
`default_nettype none
module etcf_queue (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire etcf_pkg::point_t push_data,
    input  wire logic             pop,
    output logic                  full,
    output logic                  empty,
    output etcf_pkg::point_t      pop_data
);
    import etcf_pkg::*;

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);

    point_t             mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_reg, rd_reg;
    logic [PTR_W:0]     count_reg;

    assign full = (count_reg == (PTR_W+1)'(DEPTH));
    assign empty = (count_reg == '0);
    assign pop_data = mem_reg[rd_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push) wr_reg <= wr_reg + PTR_W'(1);
            if (pop) rd_reg <= rd_reg + PTR_W'(1);
            if (push && !pop) count_reg <= count_reg + (PTR_W+1)'(1);
            else if (pop && !push) count_reg <= count_reg - (PTR_W+1)'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) mem_reg[wr_reg] <= push_data;
    end
endmodule
`default_nettype wire

/* rtl/etcf_back.sv */
`default_nettype none
`include "escape_time_cubic_fractal_pixel_top_macros.svh"
module etcf_back (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      empty,
    input  wire etcf_pkg::point_t          pop_data,
    input  wire logic [etcf_pkg::ITER_W-1:0] limit,
    output logic                           pop,
    etcf_res_if.source                     res
);
    import etcf_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SQ   = 3'd1;
    localparam logic [2:0] ST_SR   = 3'd2;
    localparam logic [2:0] ST_CU   = 3'd3;
    localparam logic [2:0] ST_ADD  = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;

    logic [2:0]              state_reg, state_next;
    logic [ITER_W-1:0]       iter_reg;
    logic signed [PT_W-1:0]  x_reg, y_reg;
    logic signed [VAL_W-1:0] pxx_reg, pyy_reg, pxy_reg;
    logic signed [VAL_W-1:0] sr_reg, si_reg;
    logic signed [VAL_W-1:0] pa_reg, pb_reg, pc_reg, pd_reg;
    logic                    esc_reg;
    logic                    res_valid_reg, res_esc_reg;

    logic [PT_W-1:0]         mag_x, mag_y;
    logic                    coarse_esc, fine_esc, at_limit;
    logic signed [VAL_W-1:0] xs, ys;
    logic signed [VAL_W+1:0] nx, ny;
    logic                    res_load;

    assign mag_x = x_reg[PT_W-1] ? PT_W'(-x_reg) : PT_W'(x_reg);
    assign mag_y = y_reg[PT_W-1] ? PT_W'(-y_reg) : PT_W'(y_reg);
    assign coarse_esc = (mag_x > ESC_TWO) || (mag_y > ESC_TWO);
    assign fine_esc = (pxx_reg + pyy_reg) > $signed(ESC_FOUR);
    assign at_limit = (iter_reg == limit);
    assign xs = x_reg[VAL_W-1:0];
    assign ys = y_reg[VAL_W-1:0];
    assign nx = (VAL_W+2)'(pa_reg) - (VAL_W+2)'(pb_reg) + (VAL_W+2)'(sr_reg);
    assign ny = (VAL_W+2)'(pc_reg) + (VAL_W+2)'(pd_reg) + (VAL_W+2)'(si_reg);

    assign pop = (state_reg == ST_IDLE) && !empty;
    assign res_load = (state_reg == ST_OUT) && (!res_valid_reg || res.ready);

    assign res.valid   = res_valid_reg;
    assign res.red     = res_esc_reg ? COLOR_ON : COLOR_OFF;
    assign res.green   = res_esc_reg ? COLOR_ON : COLOR_OFF;
    assign res.blue    = res_esc_reg ? COLOR_ON : COLOR_OFF;
    assign res.alpha   = COLOR_ON;
    assign res.escaped = res_esc_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (!empty) state_next = ST_SQ;
            ST_SQ:   state_next = (at_limit || coarse_esc) ? ST_OUT : ST_SR;
            ST_SR:   state_next = fine_esc ? ST_OUT : ST_CU;
            ST_CU:   state_next = ST_ADD;
            ST_ADD:  state_next = ST_SQ;
            ST_OUT:  if (res_load) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (res_load) res_valid_reg <= 1'b1;
            else if (res.ready) res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load) res_esc_reg <= esc_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                x_reg    <= pop_data.x;
                y_reg    <= pop_data.y;
                iter_reg <= '0;
            end
            ST_SQ:
            begin
                esc_reg <= !at_limit;
                pxx_reg <= fx_mul(xs, xs);
                pyy_reg <= fx_mul(ys, ys);
                pxy_reg <= fx_mul(xs, ys);
            end
            ST_SR:
            begin
                esc_reg  <= 1'b1;
                sr_reg   <= pxx_reg - pyy_reg;
                si_reg   <= pxy_reg <<< 1;
                iter_reg <= iter_reg + ITER_W'(1);
            end
            ST_CU:
            begin
                pa_reg <= fx_mul(sr_reg, xs);
                pb_reg <= fx_mul(si_reg, ys);
                pc_reg <= fx_mul(sr_reg, ys);
                pd_reg <= fx_mul(si_reg, xs);
            end
            ST_ADD:
            begin
                x_reg <= PT_W'(nx);
                y_reg <= PT_W'(ny);
            end
            ST_OUT: ;
            default: ;
        endcase
    end

    `ETCF_ASSERT_IMP(a_sr_after_sq, state_reg == ST_SR, $past(state_reg) == ST_SQ,
        "square stage not preceded by escape test")
    `ETCF_ASSERT_IMP(a_add_after_cu, state_reg == ST_ADD, $past(state_reg) == ST_CU,
        "update stage not preceded by cube products")
    `ETCF_ASSERT_IMP(a_iter_counted, state_reg == ST_CU, iter_reg != '0,
        "iteration not counted before cube products")
endmodule
`default_nettype wire

/* rtl/escape_time_cubic_fractal_pixel_top.sv */
// From accept to queue push the front end runs a bit-serial divide, then multiply, add
// and push; the back end then iterates the map until escape or the iteration limit.
// The front end takes a new pixel only after pushing its last point, and the back end
// a new point only after its last result is loaded; setup of the next item overlaps
// the back end. Result stalls hold the back end.
// Reset (async, active low): edges, sizes and limit take their defaults, queue empties.
`default_nettype none
module escape_time_cubic_fractal_pixel_top (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_we,
    input  wire logic [etcf_pkg::IDX_W-1:0]  cfg_index,
    input  wire logic [etcf_pkg::CFG_W-1:0]  cfg_data,
    etcf_pix_if.sink                         pixel_in,
    etcf_res_if.source                       pixel_out
);
    import etcf_pkg::*;

    cfg_t   cfg_reg;
    logic   q_push, q_pop, q_full, q_empty;
    point_t q_in, q_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.left_edge       <= -32'sd134217728;
            cfg_reg.right_edge      <= 32'sd134217728;
            cfg_reg.bottom_edge     <= -32'sd134217728;
            cfg_reg.top_edge        <= 32'sd134217728;
            cfg_reg.image_width     <= 13'd640;
            cfg_reg.image_height    <= 13'd480;
            cfg_reg.iteration_limit <= 16'd256;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_LEFT:   cfg_reg.left_edge       <= $signed(cfg_data[EDGE_W-1:0]);
                REG_RIGHT:  cfg_reg.right_edge      <= $signed(cfg_data[EDGE_W-1:0]);
                REG_BOTTOM: cfg_reg.bottom_edge     <= $signed(cfg_data[EDGE_W-1:0]);
                REG_TOP:    cfg_reg.top_edge        <= $signed(cfg_data[EDGE_W-1:0]);
                REG_WIDTH:  cfg_reg.image_width     <= cfg_data[CNT_W-1:0];
                REG_HEIGHT: cfg_reg.image_height    <= cfg_data[CNT_W-1:0];
                REG_LIMIT:  cfg_reg.iteration_limit <= cfg_data[ITER_W-1:0];
                default: ;
            endcase
        end
    end

    etcf_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix       (pixel_in),
        .cfg       (cfg_reg),
        .full      (q_full),
        .push      (q_push),
        .push_data (q_in)
    );

    etcf_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .full      (q_full),
        .empty     (q_empty),
        .pop_data  (q_out)
    );

    etcf_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .empty    (q_empty),
        .pop_data (q_out),
        .limit    (cfg_reg.iteration_limit),
        .pop      (q_pop),
        .res      (pixel_out)
    );
endmodule
`default_nettype wire
